// ===== hw/rtl/bde_pkg.sv =====
// Shared types, constants and helper functions for the button debounce event coder.
package bde_pkg;

  localparam int unsigned PortCount  = 3;
  localparam int unsigned PortWidth  = 16;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned ButtonCount = 32;
  localparam int unsigned ButtonIdxWidth = $clog2(ButtonCount);
  localparam int unsigned PortIdxWidth = $clog2(PortCount);
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [7:0] CodeHigh = 8'h80;
  localparam logic [7:0] CodeLow  = 8'h40;
  localparam logic [CountWidth-1:0] SettleReset = 8'd20;
  localparam logic [PortWidth-1:0] MaskReset = 16'hFFFF;
  localparam logic [ButtonCount-1:0] PackedReset = 32'hFFFF_FFFF;

  localparam logic [CfgIdxWidth-1:0] CfgMaskA  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMaskB  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMaskC  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgSettle = 3'd3;

  typedef enum logic [1:0] {
    StIdle,
    StDebounce,
    StPack,
    StScan
  } seq_state_e;

  typedef struct packed {
    logic [PortWidth-1:0]  last_sample;
    logic                  waiting;
    logic [CountWidth-1:0] counter;
  } port_state_t;

  typedef struct packed {
    port_state_t           state;
    logic                  taken;
    logic [PortWidth-1:0]  sample;
  } deb_result_t;

  typedef struct packed {
    logic                   start;
    logic [ButtonCount-1:0] diff;
    logic [ButtonCount-1:0] now;
  } scan_cmd_t;

  function automatic logic [4:0] btn_code_lookup(input logic [ButtonIdxWidth-1:0] idx);
    logic [4:0] code;
    case (idx)
      5'd0:  code = 5'd29;
      5'd1:  code = 5'd27;
      5'd2:  code = 5'd26;
      5'd3:  code = 5'd25;
      5'd4:  code = 5'd5;
      5'd5:  code = 5'd6;
      5'd6:  code = 5'd30;
      5'd7:  code = 5'd14;
      5'd8:  code = 5'd22;
      5'd9:  code = 5'd10;
      5'd10: code = 5'd13;
      5'd11: code = 5'd4;
      5'd12: code = 5'd19;
      5'd13: code = 5'd2;
      5'd14: code = 5'd7;
      5'd15: code = 5'd11;
      5'd16: code = 5'd1;
      5'd17: code = 5'd31;
      5'd18: code = 5'd15;
      5'd19: code = 5'd20;
      5'd20: code = 5'd18;
      5'd21: code = 5'd17;
      5'd22: code = 5'd12;
      5'd23: code = 5'd0;
      5'd24: code = 5'd21;
      5'd25: code = 5'd3;
      5'd26: code = 5'd8;
      5'd27: code = 5'd9;
      5'd28: code = 5'd16;
      5'd29: code = 5'd28;
      5'd30: code = 5'd24;
      5'd31: code = 5'd23;
      default: code = 5'd0;
    endcase
    return code;
  endfunction

  function automatic logic [ButtonCount-1:0] pack_buttons(
    input logic [PortWidth-1:0] a,
    input logic [PortWidth-1:0] b,
    input logic [PortWidth-1:0] c
  );
    logic [ButtonCount-1:0] v;
    v = {c[15:13], c[9:6], b[15:4], b[1:0], a[12:11], a[8:0]};
    return v;
  endfunction

endpackage

// ===== hw/rtl/bde_debounce_unit.sv =====
// Shared debounce step applied to one port per cycle.
module bde_debounce_unit (
  input  bde_pkg::port_state_t          cur_i,
  input  logic [bde_pkg::PortWidth-1:0]  raw_i,
  input  logic [bde_pkg::PortWidth-1:0]  mask_i,
  input  logic [bde_pkg::CountWidth-1:0] settle_i,
  output bde_pkg::deb_result_t          res_o
);
  import bde_pkg::*;

  logic [PortWidth-1:0] sample;

  always_comb begin
    sample = raw_i & mask_i;
    res_o = '0;
    res_o.sample = sample;
    res_o.state.last_sample = sample;
    res_o.state.waiting = cur_i.waiting;
    res_o.state.counter = cur_i.counter;
    res_o.taken = 1'b0;
    if (sample != cur_i.last_sample) begin
      if (cur_i.waiting) begin
        res_o.state.counter = '0;
      end else begin
        res_o.state.waiting = 1'b1;
      end
    end else if (cur_i.waiting) begin
      res_o.state.counter = cur_i.counter + 1'b1;
      if (cur_i.counter == settle_i) begin
        res_o.state.waiting = 1'b0;
        res_o.state.counter = '0;
        res_o.taken = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bde_event_scan.sv =====
// Bit scanner that turns a change mask into a stream of event items.
module bde_event_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bde_pkg::scan_cmd_t     cmd_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             event_code_o,
  output logic                   last_event_o
);
  import bde_pkg::*;

  logic [ButtonCount-1:0]    diff_q, diff_d;
  logic [ButtonCount-1:0]    now_q, now_d;
  logic [ButtonIdxWidth-1:0] idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic [7:0]                code_q, code_d;
  logic                      last_q, last_d;
  logic                      slot_free;
  logic [ButtonCount-1:0]    rest;

  always_comb begin
    slot_free = !valid_q || out_ready_i;
    rest = diff_q;
    rest[idx_q] = 1'b0;
    diff_d = diff_q;
    now_d = now_q;
    idx_d = idx_q;
    valid_d = valid_q && !out_ready_i;
    code_d = code_q;
    last_d = last_q;
    if (cmd_i.start) begin
      diff_d = cmd_i.diff;
      now_d = cmd_i.now;
      idx_d = '0;
    end else if (diff_q != '0) begin
      if (!diff_q[idx_q]) begin
        idx_d = idx_q + 1'b1;
      end else if (slot_free) begin
        valid_d = 1'b1;
        code_d = (now_q[idx_q] ? CodeHigh : CodeLow) | {3'b000, btn_code_lookup(idx_q)};
        last_d = (rest == '0);
        diff_d = rest;
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
      idx_q <= '0;
      valid_q <= 1'b0;
    end else begin
      diff_q <= diff_d;
      idx_q <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign busy_o = (diff_q != '0);
  assign out_valid_o = valid_q;
  assign event_code_o = code_q;
  assign last_event_o = last_q;

endmodule

// ===== hw/rtl/button_debounce_event_coder.sv =====
// Top level of the button debounce event coder: sequencer, port state and configuration.
// Flow: an accepted item is debounced port by port, then packed if any port settled; if the packed
// buttons changed, the scanner walks the button bits in order up to the last changed bit and
// emits one event per changed bit, waiting while the output stalls. A new item is accepted only
// while the sequencer is idle and the scanner is not busy.
// Reset: masks and samples return to all ones, settle count to 20, counters clear.
module button_debounce_event_coder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bde_pkg::PortWidth-1:0]    raw_port_a_i,
  input  logic [bde_pkg::PortWidth-1:0]    raw_port_b_i,
  input  logic [bde_pkg::PortWidth-1:0]    raw_port_c_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       event_code_o,
  output logic                             last_event_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bde_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bde_pkg::PortWidth-1:0]    cfg_data_i
);
  import bde_pkg::*;

  seq_state_e state_q, state_d;
  logic [PortIdxWidth-1:0] port_q, port_d;
  logic any_q, any_d;
  logic [PortWidth-1:0] raw_q [PortCount];
  logic [PortWidth-1:0] mask_q [PortCount];
  logic [CountWidth-1:0] settle_q;
  port_state_t pst_q [PortCount];
  logic [PortWidth-1:0] stable_q [PortCount];
  logic [ButtonCount-1:0] packed_q;
  logic [ButtonCount-1:0] now_w;
  deb_result_t deb_res;
  scan_cmd_t scan_cmd;
  logic scan_busy;
  logic in_acc;
  logic last_port;

  assign in_acc = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign last_port = (port_q == PortIdxWidth'(PortCount - 1));
  assign now_w = pack_buttons(stable_q[0], stable_q[1], stable_q[2]);

  bde_debounce_unit u_deb (
    .cur_i    (pst_q[port_q]),
    .raw_i    (raw_q[port_q]),
    .mask_i   (mask_q[port_q]),
    .settle_i (settle_q),
    .res_o    (deb_res)
  );

  always_comb begin
    state_d = state_q;
    port_d = port_q;
    any_d = any_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StDebounce;
          port_d = '0;
          any_d = 1'b0;
        end
      end
      StDebounce: begin
        any_d = any_q || deb_res.taken;
        port_d = last_port ? '0 : port_q + 1'b1;
        if (last_port) begin
          state_d = (any_q || deb_res.taken) ? StPack : StIdle;
        end
      end
      StPack: begin
        state_d = ((now_w ^ packed_q) != '0) ? StScan : StIdle;
      end
      StScan: begin
        if (!scan_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == StIdle) && !scan_busy;
    scan_cmd.start = (state_q == StPack) && ((now_w ^ packed_q) != '0);
    scan_cmd.diff = now_w ^ packed_q;
    scan_cmd.now = now_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      port_q <= '0;
      any_q <= 1'b0;
      settle_q <= SettleReset;
      packed_q <= PackedReset;
      for (int p = 0; p < PortCount; p++) begin
        mask_q[p] <= MaskReset;
        pst_q[p] <= '{last_sample: MaskReset, waiting: 1'b0, counter: '0};
        stable_q[p] <= MaskReset;
      end
    end else begin
      state_q <= state_d;
      port_q <= port_d;
      any_q <= any_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMaskA:  mask_q[0] <= cfg_data_i;
          CfgMaskB:  mask_q[1] <= cfg_data_i;
          CfgMaskC:  mask_q[2] <= cfg_data_i;
          CfgSettle: settle_q <= cfg_data_i[CountWidth-1:0];
          default: ;
        endcase
      end
      if (state_q == StDebounce) begin
        pst_q[port_q] <= deb_res.state;
        if (deb_res.taken) begin
          stable_q[port_q] <= deb_res.sample;
        end
      end
      if (state_q == StPack) begin
        packed_q <= now_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q[0] <= raw_port_a_i;
      raw_q[1] <= raw_port_b_i;
      raw_q[2] <= raw_port_c_i;
    end
  end

  bde_event_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (scan_cmd),
    .busy_o       (scan_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .last_event_o (last_event_o)
  );

  a_port_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_q <= PortIdxWidth'(PortCount - 1))
    else $error("port index out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StDebounce) && (port_q == '0))
    else $error("accepted item did not start debouncing at port zero");

  a_pack_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPack) |-> ($past(state_q) == StDebounce))
    else $error("pack step without preceding debounce");

  a_no_scan_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cmd.start |-> !scan_busy)
    else $error("scanner restarted while busy");

endmodule

// ===== bench/tb_button_debounce_event_coder.sv =====
// Testbench for the button debounce event coder: directed and random scan ticks checked against a predictor.
module tb_button_debounce_event_coder;
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned RandomTicks = 460;

  localparam logic [4:0] KeyCodeTable [ButtonCount] = '{
    5'd29, 5'd27, 5'd26, 5'd25, 5'd5,  5'd6,  5'd30, 5'd14,
    5'd22, 5'd10, 5'd13, 5'd4,  5'd19, 5'd2,  5'd7,  5'd11,
    5'd1,  5'd31, 5'd15, 5'd20, 5'd18, 5'd17, 5'd12, 5'd0,
    5'd21, 5'd3,  5'd8,  5'd9,  5'd16, 5'd28, 5'd24, 5'd23
  };

  typedef struct packed {
    logic [PortWidth-1:0] a;
    logic [PortWidth-1:0] b;
    logic [PortWidth-1:0] c;
  } scan_tick_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_event_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [PortWidth-1:0]   raw_port_a_i = '0;
  logic [PortWidth-1:0]   raw_port_b_i = '0;
  logic [PortWidth-1:0]   raw_port_c_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [7:0]             event_code_o;
  logic                   last_event_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [PortWidth-1:0]   cfg_data_i = '0;

  button_debounce_event_coder dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .raw_port_a_i,
    .raw_port_b_i,
    .raw_port_c_i,
    .out_valid_o,
    .out_ready_i,
    .event_code_o,
    .last_event_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Predicted block state and configuration.
  logic [PortWidth-1:0]   key_mask [PortCount];
  logic [CountWidth-1:0]  settle_target;
  logic [PortWidth-1:0]   seen_word [PortCount];
  logic                   wait_active [PortCount];
  logic [CountWidth-1:0]  quiet_ticks [PortCount];
  logic [PortWidth-1:0]   debounced_word [PortCount];
  logic [ButtonCount-1:0] key_state;

  scan_tick_t  pending_ticks [$];
  key_event_t  expected_events [$];
  logic [PortWidth-1:0] next_word [PortCount];
  scan_tick_t  tick_out;
  key_event_t  event_want;

  int unsigned ticks_queued = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  logic        receiver_hold;

  assign receiver_hold = (hold_left != 0);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ButtonCount-1:0] pack_keys();
    logic [31:0] wa, wb, wc, v;
    wa = {16'h0000, debounced_word[0]};
    wb = {16'h0000, debounced_word[1]};
    wc = {16'h0000, debounced_word[2]};
    v = (wa & 32'h01FF) | ((wa >> 2) & 32'h0600);
    v |= ((wb & 32'h0003) | ((wb >> 2) & 32'h3FFC)) << 11;
    v |= (((wc >> 6) & 32'h000F) | ((wc >> 9) & 32'h0070)) << 25;
    return v;
  endfunction

  function automatic void reset_keypad_model();
    for (int p = 0; p < PortCount; p++) begin
      key_mask[p] = MaskReset;
      seen_word[p] = MaskReset;
      wait_active[p] = 1'b0;
      quiet_ticks[p] = '0;
      debounced_word[p] = MaskReset;
      next_word[p] = MaskReset;
    end
    settle_target = SettleReset;
    key_state = PackedReset;
  endfunction

  function automatic void predict_key_events(input scan_tick_t t);
    logic [PortWidth-1:0]   raw [PortCount];
    logic [PortWidth-1:0]   smp;
    logic [CountWidth-1:0]  prior;
    logic [ButtonCount-1:0] now, diff;
    logic                   any_taken;
    key_event_t             ev;
    raw = '{t.a, t.b, t.c};
    any_taken = 1'b0;
    for (int p = 0; p < PortCount; p++) begin
      smp = raw[p] & key_mask[p];
      if (smp != seen_word[p]) begin
        if (wait_active[p]) quiet_ticks[p] = '0;
        else wait_active[p] = 1'b1;
      end else if (wait_active[p]) begin
        prior = quiet_ticks[p];
        quiet_ticks[p] = prior + 8'd1;
        if (prior == settle_target) begin
          wait_active[p] = 1'b0;
          quiet_ticks[p] = '0;
          debounced_word[p] = smp;
          any_taken = 1'b1;
        end
      end
      seen_word[p] = smp;
    end
    if (!any_taken) return;
    now = pack_keys();
    diff = now ^ key_state;
    key_state = now;
    for (int i = 0; i < ButtonCount; i++) begin
      if (diff[i]) begin
        ev.code = (now[i] ? CodeHigh : CodeLow) | {3'b000, KeyCodeTable[i]};
        ev.last = ((diff >> i) == 32'd1);
        expected_events.push_back(ev);
      end
    end
  endfunction

  // Sender: offers queued scan ticks and predicts on each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_key_events('{raw_port_a_i, raw_port_b_i, raw_port_c_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_out = pending_ticks.pop_front();
          raw_port_a_i <= tick_out.a;
          raw_port_b_i <= tick_out.b;
          raw_port_c_i <= tick_out.c;
          in_valid_i <= 1'b1;
          tx_gap_left = tx_idle_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted event against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected item: event_code %h last_event %b", event_code_o, last_event_o);
          errors++;
        end else begin
          event_want = expected_events.pop_front();
          if (event_code_o !== event_want.code) begin
            $error("event_code: expected %h, actual %h", event_want.code, event_code_o);
            errors++;
          end
          if (last_event_o !== event_want.last) begin
            $error("last_event: expected %b, actual %b", event_want.last, last_event_o);
            errors++;
          end
        end
      end
      if (receiver_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_stall_left = rx_idle_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      hold_left <= LongHold;
      holds_served <= holds_served + 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic queue_tick(input logic [PortWidth-1:0] a, b, c);
    pending_ticks.push_back('{a, b, c});
    next_word = '{a, b, c};
    ticks_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [PortWidth-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgMaskA, CfgMaskB, CfgMaskC: key_mask[idx] = data;
      CfgSettle: settle_target = data[CountWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [PortWidth-1:0] ma, mb, mc,
                           input logic [CountWidth-1:0] settle);
    write_reg(CfgMaskA, ma);
    write_reg(CfgMaskB, mb);
    write_reg(CfgMaskC, mc);
    write_reg(CfgSettle, {8'h00, settle});
    if ($urandom_range(3) == 0) begin
      write_reg(CfgIdxWidth'(CfgSettle + $urandom_range(1, 4)), 16'($urandom));
    end
  endtask

  function automatic logic [PortWidth-1:0] pick_mask();
    case ($urandom_range(3))
      0: return MaskReset;
      1: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_noise(input int unsigned n);
    repeat (n) queue_tick(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // A press or release: optional contact bounce, then the new levels held long enough.
  task automatic queue_keypress();
    logic [PortWidth-1:0] target [PortCount];
    logic [PortWidth-1:0] bounce [PortCount];
    int unsigned bounces;
    int unsigned steady;
    target = next_word;
    for (int p = 0; p < PortCount; p++) begin
      case ($urandom_range(3))
        0: target[p] = 16'($urandom);
        1: target[p] ^= 16'(1) << $urandom_range(15);
        2: target[p] ^= 16'($urandom) & 16'($urandom);
        default: ;
      endcase
    end
    bounces = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (bounces) begin
      for (int p = 0; p < PortCount; p++) begin
        bounce[p] = target[p] ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
      end
      queue_tick(bounce[0], bounce[1], bounce[2]);
    end
    steady = settle_target + 2 + $urandom_range(0, 2);
    repeat (steady) queue_tick(target[0], target[1], target[2]);
  endtask

  task automatic run_random_phase(input int unsigned n);
    int unsigned first;
    configure(pick_mask(), pick_mask(), pick_mask(),
              ($urandom_range(4) == 0) ? 8'($urandom_range(4, 8)) : 8'($urandom_range(0, 3)));
    tx_idle_on = ($urandom_range(3) != 0);
    rx_idle_on = ($urandom_range(3) != 0);
    first = ticks_queued;
    while (ticks_queued - first < n) begin
      if ($urandom_range(4) == 0) queue_noise($urandom_range(1, 3));
      else queue_keypress();
    end
    wait_idle();
  endtask

  initial begin
    logic [PortWidth-1:0] a, b, c;
    int unsigned directed_ticks;
    reset_keypad_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(MaskReset, MaskReset, MaskReset, 8'd0);
    for (int i = CfgSettle + 1; i < 2 ** CfgIdxWidth; i++) begin
      write_reg(i[CfgIdxWidth-1:0], 16'h0001);
    end
    repeat (2) queue_tick(16'h0000, 16'h0000, 16'h0000);
    repeat (2) queue_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (2) queue_tick(16'h19FF, 16'hFFF3, 16'hE3C0);
    repeat (2) queue_tick(16'hFFFE, 16'hFFFF, 16'hE3C0);
    repeat (2) queue_tick(16'hFFFF, 16'h7FFF, 16'h63C0);
    wait_idle();
    configure(16'h0000, MaskReset, MaskReset, 8'd1);
    repeat (2) queue_tick(16'hFFFF, 16'h7FFF, 16'h63C0);
    queue_tick(16'h1234, 16'h7FFF, 16'h63C0);
    repeat (2) queue_tick(16'h1234, 16'h0000, 16'h63C0);
    repeat (3) queue_tick(16'h1234, 16'h5555, 16'h63C0);
    wait_idle();
    directed_ticks = ticks_queued;

    // The receiver holds off while the sender keeps offering busy ticks.
    configure(MaskReset, MaskReset, MaskReset, 8'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_requests++;
    repeat (15) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      repeat (2) queue_tick(a, b, c);
    end
    wait_idle();

    while (ticks_queued - directed_ticks < 160) run_random_phase($urandom_range(30, 50));

    // Longest settle count, then a lower one that makes a running counter wrap.
    configure(MaskReset, MaskReset, MaskReset, 8'd255);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    a = next_word[0] ^ 16'h0001;
    b = next_word[1];
    queue_tick(a, b, next_word[2]);
    c = next_word[2] ^ 16'h0040;
    repeat (256) queue_tick(a, b, c);
    wait_idle();
    configure(MaskReset, MaskReset, MaskReset, 8'd10);
    repeat (12) queue_tick(a, b, c);
    wait_idle();

    while (ticks_queued - directed_ticks < RandomTicks) begin
      run_random_phase($urandom_range(30, 50));
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
